// ===== hdl/lbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbb_pkg
// Shared constants, codes and types for the byte-budget LRU table.
// ----------------------------------------------------------------------------
package lbb_pkg;

	// Table geometry and field widths
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int SIZE_BITS  = 32;
	localparam int LIMIT_BITS = 32;
	localparam int BYTES_BITS = 36;
	localparam int CNT_BITS   = 5;

	localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = LIMIT_BITS'(4 * 1024 * 1024);

	// Operation codes carried on the mode field
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_TRIM   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	// One table entry as held in a cell
	typedef struct packed {
		logic                 valid;
		logic [KEY_BITS-1:0]  key;
		logic [SIZE_BITS-1:0] size;
	} entry_t;

	// Per-cell operation
	typedef enum logic [2:0] {
		CELL_HOLD  = 3'd0,
		CELL_DOWN  = 3'd1,	// take the entry of the more recent neighbor
		CELL_UP    = 3'd2,	// take the entry of the less recent neighbor
		CELL_DROP  = 3'd3,
		CELL_CLEAR = 3'd4
	} cell_op_t;

	// Commands from the sequencer to the chain
	typedef struct packed {
		logic hit_move;
		logic remove;
		logic evict;
		logic insert;
		logic clear;
	} chain_cmd_t;

	// Status from the chain to the sequencer
	typedef struct packed {
		logic                 any_match;
		logic                 nonempty;
		logic                 full;
		logic [SIZE_BITS-1:0] match_size;
		logic [SIZE_BITS-1:0] lru_size;
	} chain_sts_t;

endpackage

// ===== hdl/lbb_cell.sv =====
// ----------------------------------------------------------------------------
// lbb_cell
// One position of the recency chain: holds an entry, compares its key and
// takes its neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lbb_cell import lbb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_op_t            op,
	input  entry_t              prev_ent,
	input  entry_t              next_ent,
	input  logic [KEY_BITS-1:0] cmp_key,
	output entry_t              ent,
	output logic                match
);

	logic                 valid_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [SIZE_BITS-1:0] size_q;

	// Valid bit: control state, reset clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_DOWN:  valid_q <= prev_ent.valid;
				CELL_UP:    valid_q <= next_ent.valid;
				CELL_DROP:  valid_q <= 1'b0;
				CELL_CLEAR: valid_q <= 1'b0;
				default:    valid_q <= valid_q;
			endcase
		end
	end

	// Key and size payload
	always_ff @(posedge clk) begin
		case (op)
			CELL_DOWN: begin
				key_q  <= prev_ent.key;
				size_q <= prev_ent.size;
			end
			CELL_UP: begin
				key_q  <= next_ent.key;
				size_q <= next_ent.size;
			end
			default: begin
				key_q  <= key_q;
				size_q <= size_q;
			end
		endcase
	end

	assign ent   = '{valid: valid_q, key: key_q, size: size_q};
	assign match = valid_q && (key_q == cmp_key);

endmodule

// ===== hdl/lbb_chain.sv =====
// ----------------------------------------------------------------------------
// lbb_chain
// Row of cells ordered by recency: position 0 is most recent, valid entries
// form a prefix. Decodes sequencer commands into per-cell shift operations.
// ----------------------------------------------------------------------------
module lbb_chain import lbb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  chain_cmd_t          cmd,
	input  entry_t              head_ent,
	input  logic [KEY_BITS-1:0] cmp_key,
	output chain_sts_t          sts
);

	entry_t               ent     [ENTRIES];
	cell_op_t             op      [ENTRIES];
	logic [ENTRIES-1:0]   match_v;
	logic [ENTRIES-1:0]   valid_v;
	logic [ENTRIES-1:0]   last_v;
	logic [ENTRIES-1:0]   match_ge;	// a match at this position or further back
	logic [ENTRIES-1:0]   match_le;	// a match at this position or nearer the head
	logic [SIZE_BITS-1:0] match_size;
	logic [SIZE_BITS-1:0] lru_size;

	// Cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;

		if (i == 0) begin : g_head
			assign prev_ent = head_ent;
		end else begin : g_mid
			assign prev_ent = ent[i-1];
		end

		if (i == ENTRIES - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_body
			assign next_ent = ent[i+1];
		end

		lbb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op[i]),
			.prev_ent (prev_ent),
			.next_ent (next_ent),
			.cmp_key  (cmp_key),
			.ent      (ent[i]),
			.match    (match_v[i])
		);

		assign valid_v[i] = ent[i].valid;
	end

	// Least-recent valid entry sits at the end of the valid prefix
	assign last_v = valid_v & ~(valid_v >> 1);

	// Match position masks
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_ge[i] = |(match_v & ~((ENTRIES)'((1 << i) - 1)));
			match_le[i] = |(match_v & (ENTRIES)'((2 << i) - 1));
		end
	end

	// Per-cell operation decode
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.clear) begin
				op[i] = CELL_CLEAR;
			end else if (cmd.insert) begin
				op[i] = CELL_DOWN;
			end else if (cmd.hit_move && match_ge[i]) begin
				op[i] = CELL_DOWN;
			end else if (cmd.remove && match_le[i]) begin
				op[i] = CELL_UP;
			end else if (cmd.evict && last_v[i]) begin
				op[i] = CELL_DROP;
			end else begin
				op[i] = CELL_HOLD;
			end
		end
	end

	// Size of the matching entry and of the least-recent entry
	always_comb begin
		match_size = '0;
		lru_size   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_size = match_size | (ent[i].size & {SIZE_BITS{match_v[i]}});
			lru_size   = lru_size   | (ent[i].size & {SIZE_BITS{last_v[i]}});
		end
	end

	assign sts = '{
		any_match:  |match_v,
		nonempty:   valid_v[0],
		full:       valid_v[ENTRIES-1],
		match_size: match_size,
		lru_size:   lru_size
	};

endmodule

// ===== hdl/lru_cache_byte_budget_unit.sv =====
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_unit
// Keyed LRU table with per-entry byte sizes and a programmable byte budget.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Beat contents
// in       in   in_valid / in_stall   mode, key, entry_size
// out      out  out_valid / out_stall hit, removed, evicted_count, bytes_in_use
// cfg      in   cfg_we                cfg_wdata (cache_limit)
//
// One item at a time. Lookup hit, remove, key zero and clear go to the final
// step; trim runs the trim step, a lookup miss the trim, capacity and insert
// steps (trim evicts one least-recent entry per cycle while over budget).
// Reset empties the table, zeroes bytes in use, loads the default budget.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in the final step until the register is free.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_unit import lbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input beat
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [SIZE_BITS-1:0]  entry_size,
	// result beat
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic                  removed,
	output logic [CNT_BITS-1:0]   evicted_count,
	output logic [BYTES_BITS-1:0] bytes_in_use,
	// budget register
	input  logic                  cfg_we,
	input  logic [LIMIT_BITS-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TRIM = 5'b00010,
		ST_CAP  = 5'b00100,
		ST_INS  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [BYTES_BITS-1:0] bytes_q;
	logic [BYTES_BITS-1:0] bytes_d;
	logic [KEY_BITS-1:0]   key_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic                  insert_q;
	logic                  insert_d;
	logic                  hit_q;
	logic                  hit_d;
	logic                  removed_q;
	logic                  removed_d;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [CNT_BITS-1:0]   cnt_d;
	logic                  out_valid_q;
	logic                  hit_out_q;
	logic                  removed_out_q;
	logic [CNT_BITS-1:0]   cnt_out_q;
	logic [BYTES_BITS-1:0] bytes_out_q;
	logic                  in_beat;
	logic                  out_load;
	logic                  over_budget;
	chain_cmd_t            cmd;
	chain_sts_t            sts;
	entry_t                head_ent;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_beat     = in_valid && !in_stall;
	assign out_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign over_budget = sts.nonempty && (bytes_q > BYTES_BITS'(limit_q));

	// Recency chain
	lbb_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.head_ent (head_ent),
		.cmp_key  (key),
		.sts      (sts)
	);

	// New head entry: the hit entry on a move, the new key on insert
	always_comb begin
		if (state_q == ST_INS) begin
			head_ent = '{valid: 1'b1, key: key_q, size: size_q};
		end else begin
			head_ent = '{valid: 1'b1, key: key, size: sts.match_size};
		end
	end

	// Sequencer
	always_comb begin
		state_d   = state_q;
		bytes_d   = bytes_q;
		insert_d  = insert_q;
		hit_d     = hit_q;
		removed_d = removed_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					hit_d     = 1'b0;
					removed_d = 1'b0;
					cnt_d     = '0;
					insert_d  = 1'b0;
					state_d   = ST_FIN;
					case (mode)
						MODE_LOOKUP: begin
							if (key != '0) begin
								if (sts.any_match) begin
									cmd.hit_move = 1'b1;
									hit_d        = 1'b1;
								end else begin
									insert_d = 1'b1;
									state_d  = ST_TRIM;
								end
							end
						end
						MODE_REMOVE: begin
							if ((key != '0) && sts.any_match) begin
								cmd.remove = 1'b1;
								removed_d  = 1'b1;
								bytes_d    = bytes_q - BYTES_BITS'(sts.match_size);
							end
						end
						MODE_TRIM: begin
							state_d = ST_TRIM;
						end
						MODE_CLEAR: begin
							cmd.clear = 1'b1;
							bytes_d   = '0;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_TRIM: begin
				if (over_budget) begin
					cmd.evict = 1'b1;
					bytes_d   = bytes_q - BYTES_BITS'(sts.lru_size);
					cnt_d     = cnt_q + 1'b1;
				end else if (insert_q) begin
					state_d = ST_CAP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_CAP: begin
				// a full table gives up its least-recent entry
				if (sts.full) begin
					cmd.evict = 1'b1;
					bytes_d   = bytes_q - BYTES_BITS'(sts.lru_size);
					cnt_d     = cnt_q + 1'b1;
				end
				state_d = ST_INS;
			end
			ST_INS: begin
				cmd.insert = 1'b1;
				bytes_d    = bytes_q + BYTES_BITS'(size_q);
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= DEFAULT_LIMIT;
			bytes_q     <= '0;
			insert_q    <= 1'b0;
			hit_q       <= 1'b0;
			removed_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			bytes_q   <= bytes_d;
			insert_q  <= insert_d;
			hit_q     <= hit_d;
			removed_q <= removed_d;
			cnt_q     <= cnt_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload and result register
	always_ff @(posedge clk) begin
		if (in_beat) begin
			key_q  <= key;
			size_q <= entry_size;
		end
		if (out_load) begin
			hit_out_q     <= hit_q;
			removed_out_q <= removed_q;
			cnt_out_q     <= cnt_q;
			bytes_out_q   <= bytes_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_out_q;
	assign removed       = removed_out_q;
	assign evicted_count = cnt_out_q;
	assign bytes_in_use  = bytes_out_q;

endmodule

// ===== hdl/lbb_checker.sv =====
// ----------------------------------------------------------------------------
// lbb_checker
// Port-level checks for the byte-budget LRU table, bound to the top level.
// ----------------------------------------------------------------------------
module lbb_checker import lbb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic                  removed,
	input logic [CNT_BITS-1:0]   evicted_count,
	input logic [BYTES_BITS-1:0] bytes_in_use
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(removed)
			&& $stable(evicted_count) && $stable(bytes_in_use))
		else $error("result beat changed under stall");

	// One item at a time: the block is busy right after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	// Hit and removed come from different operations
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && removed))
		else $error("hit and removed both set");

	// Hits and removes never evict, and evictions never exceed the depth
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((hit || removed) ? (evicted_count == '0)
			: (evicted_count <= CNT_BITS'(ENTRIES))))
		else $error("eviction count out of range");

endmodule

bind lru_cache_byte_budget_unit lbb_checker u_lbb_checker (.*);

// ===== dv/lru_cache_byte_budget_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_unit_tb
// Self-checking bench for the byte-budget LRU table. A queue-fed driver
// offers lookup, remove, trim and clear beats. A shadow table in the bench
// predicts hit, removed, evicted count and bytes in use for every accepted
// beat. A monitor checks each result beat against the oldest prediction.
// The budget is reprogrammed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_unit_tb;
	import lbb_pkg::*;

	localparam int HOLD_CYCLES    = 200;	// long receiver hold-off
	localparam int SETTLE_CYCLES  = 40;		// quiet time before a budget write
	localparam int WATCHDOG_LIMIT = 3000;	// cycles without any beat
	localparam int PHASE_ITEMS    = 290;

	typedef struct packed {
		logic [1:0]           op;
		logic [KEY_BITS-1:0]  id;
		logic [SIZE_BITS-1:0] nbytes;
	} lru_item_t;

	typedef struct packed {
		logic                  hit;
		logic                  removed;
		logic [CNT_BITS-1:0]   evicted;
		logic [BYTES_BITS-1:0] bytes;
	} lru_result_t;

	// DUT ports
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode       = MODE_LOOKUP;
	logic [KEY_BITS-1:0]   key        = '0;
	logic [SIZE_BITS-1:0]  entry_size = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  hit;
	logic                  removed;
	logic [CNT_BITS-1:0]   evicted_count;
	logic [BYTES_BITS-1:0] bytes_in_use;
	logic                  cfg_we     = 1'b0;
	logic [LIMIT_BITS-1:0] cfg_wdata  = '0;

	// Shadow table
	logic [LIMIT_BITS-1:0] budget = DEFAULT_LIMIT;
	bit                    t_valid [ENTRIES];
	logic [KEY_BITS-1:0]   t_key   [ENTRIES];
	logic [SIZE_BITS-1:0]  t_size  [ENTRIES];
	int                    t_rank  [ENTRIES];
	logic [BYTES_BITS-1:0] t_bytes = '0;

	lru_item_t   pending_items[$];
	lru_result_t expected_results[$];
	lru_item_t   cur_item;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	int errors         = 0;
	int items_in       = 0;
	int results_seen   = 0;
	int hits_seen      = 0;
	int evictions_seen = 0;
	int budgets_set    = 0;

	lru_cache_byte_budget_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.key           (key),
		.entry_size    (entry_size),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.removed       (removed),
		.evicted_count (evicted_count),
		.bytes_in_use  (bytes_in_use),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- shadow table
	function automatic int occupancy();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (t_valid[i]) n++;
		return n;
	endfunction

	function automatic int find_slot(logic [KEY_BITS-1:0] k);
		int s;
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (t_valid[i] && t_key[i] == k && s < 0) s = i;
		return s;
	endfunction

	// drop one slot and close the rank gap behind it
	function automatic void drop_slot(int s);
		int r;
		r = t_rank[s];
		t_valid[s] = 1'b0;
		t_bytes -= t_size[s];
		for (int i = 0; i < ENTRIES; i++)
			if (t_valid[i] && t_rank[i] > r) t_rank[i]--;
	endfunction

	function automatic void evict_oldest();
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (t_valid[i] && (best < 0 || t_rank[i] > t_rank[best])) best = i;
		if (best >= 0) drop_slot(best);
	endfunction

	function automatic int budget_trim();
		int n;
		n = 0;
		while (occupancy() > 0 && t_bytes > {4'd0, budget}) begin
			evict_oldest();
			n++;
		end
		return n;
	endfunction

	function automatic lru_result_t cache_apply(lru_item_t it);
		lru_result_t res;
		int s;
		int r;
		res = '0;
		case (it.op)
			MODE_LOOKUP: begin
				if (it.id != '0) begin
					s = find_slot(it.id);
					if (s >= 0) begin
						// hit: promote to most recent, size ignored
						res.hit = 1'b1;
						r = t_rank[s];
						for (int i = 0; i < ENTRIES; i++)
							if (t_valid[i] && i != s && t_rank[i] < r) t_rank[i]++;
						t_rank[s] = 0;
					end else begin
						// miss: budget evictions, then capacity eviction, then insert
						res.evicted = CNT_BITS'(budget_trim());
						if (occupancy() >= ENTRIES) begin
							evict_oldest();
							res.evicted++;
						end
						for (int i = 0; i < ENTRIES; i++)
							if (t_valid[i]) t_rank[i]++;
						s = -1;
						for (int i = 0; i < ENTRIES; i++)
							if (!t_valid[i] && s < 0) s = i;
						t_valid[s] = 1'b1;
						t_key[s]   = it.id;
						t_size[s]  = it.nbytes;
						t_rank[s]  = 0;
						t_bytes += it.nbytes;
					end
				end
			end
			MODE_REMOVE: begin
				if (it.id != '0) begin
					s = find_slot(it.id);
					if (s >= 0) begin
						drop_slot(s);
						res.removed = 1'b1;
					end
				end
			end
			MODE_TRIM: res.evicted = CNT_BITS'(budget_trim());
			default: begin
				for (int i = 0; i < ENTRIES; i++) t_valid[i] = 1'b0;
				t_bytes = '0;
			end
		endcase
		res.bytes = t_bytes;
		return res;
	endfunction

	// ---------------------------------------------------------------- driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(cache_apply(cur_item));
				items_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					in_valid   <= 1'b1;
					mode       <= cur_item.op;
					key        <= cur_item.id;
					entry_size <= cur_item.nbytes;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic flag_error(string msg);
		if (errors < 10) $display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		lru_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit || removed !== want.removed ||
					    evicted_count !== want.evicted || bytes_in_use !== want.bytes)
						flag_error($sformatf(
							"exp hit %0b rm %0b ev %0d bytes %0d, got hit %0b rm %0b ev %0d bytes %0d",
							want.hit, want.removed, want.evicted, want.bytes,
							hit, removed, evicted_count, bytes_in_use));
					if (want.hit) hits_seen++;
					evictions_seen += want.evicted;
				end
			end
			// receiver back-pressure: long hold-off on request, else random
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, expected_results.size());
				$display("lru_cache_byte_budget_unit regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic push_item(logic [1:0] op, logic [31:0] id, logic [31:0] nbytes);
		lru_item_t it;
		it.op     = op;
		it.id     = id;
		it.nbytes = nbytes;
		pending_items.push_back(it);
	endtask

	task automatic push_random();
		int p;
		int q;
		logic [1:0]  op;
		logic [31:0] id;
		logic [31:0] nbytes;
		p = $urandom_range(99);
		if (p < 69)      op = MODE_LOOKUP;
		else if (p < 87) op = MODE_REMOVE;
		else if (p < 97) op = MODE_TRIM;
		else             op = MODE_CLEAR;
		// small key pool so hits and removes find entries
		q = $urandom_range(99);
		if (q < 4)       id = '0;
		else if (q < 10) id = $urandom;
		else             id = $urandom_range(24, 1);
		q = $urandom_range(99);
		if (q < 30)      nbytes = $urandom_range(255, 0);
		else if (q < 60) nbytes = $urandom_range(budget / 4, 0);
		else if (q < 80) nbytes = $urandom_range(budget / 12, 0);
		else if (q < 90) nbytes = $urandom;
		else begin
			case ($urandom_range(3))
				0:       nbytes = '0;
				1:       nbytes = '1;
				2:       nbytes = budget;
				default: nbytes = budget + 1;
			endcase
		end
		push_item(op, id, nbytes);
	endtask

	// all items sent, all results back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_budget(logic [LIMIT_BITS-1:0] lim);
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		budget = lim;
		budgets_set++;
		@(negedge clk);
	endtask

	task automatic run_phase(int p, logic [LIMIT_BITS-1:0] lim);
		wait_drained();
		set_budget(lim);
		if (p < 2) begin
			send_idle_pct = 18;
			recv_idle_pct = 76;
		end else if (p < 4) begin
			send_idle_pct = 76;
			recv_idle_pct = 18;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if (p == 1 || p == 4) hold_reqs++;
		// trim right after the new budget
		push_item(MODE_TRIM, $urandom, $urandom);
		repeat (PHASE_ITEMS / 2) push_random();
		// sender pause until the unit has drained
		wait_drained();
		repeat (PHASE_ITEMS - PHASE_ITEMS / 2) push_random();
	endtask

	initial begin
		logic [LIMIT_BITS-1:0] budgets [6];
		budgets = '{32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd0, 32'd1, DEFAULT_LIMIT};
		budgets[3] = $urandom;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset budget
		send_idle_pct = 18;
		recv_idle_pct = 76;
		push_item(MODE_LOOKUP, 32'd0, 32'd5);				// key zero ignored
		push_item(MODE_REMOVE, 32'd0, 32'd0);				// key zero never found
		push_item(MODE_TRIM,   32'd0, 32'd0);				// trim on empty table
		push_item(MODE_CLEAR,  32'd0, 32'd0);				// clear on empty table
		push_item(MODE_LOOKUP, 32'd1, 32'd100);				// miss, insert
		push_item(MODE_LOOKUP, 32'd1, 32'd777);				// hit, size ignored
		push_item(MODE_REMOVE, 32'd99, 32'd0);				// absent key
		push_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);	// oversize entry
		push_item(MODE_LOOKUP, 32'd2, 32'd0);				// evicts down to budget
		push_item(MODE_REMOVE, 32'd2, 32'd0);				// present key
		for (int i = 0; i < ENTRIES + 1; i++)			// last one hits capacity
			push_item(MODE_LOOKUP, 32'h10 + i, 32'd1000);
		push_item(MODE_TRIM,   32'd0, 32'd0);				// under budget
		push_item(MODE_CLEAR,  32'd0, 32'd0);				// clear full table

		for (int p = 0; p < 6; p++)
			run_phase(p, budgets[p]);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d beats in, %0d results, %0d hits, %0d evictions",
			items_in, results_seen, hits_seen, evictions_seen);
		$display("over %0d budget settings incl. 0 and all-ones, with idle and hold-off",
			budgets_set);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("lru_cache_byte_budget_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_results.size());
			$display("lru_cache_byte_budget_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lbb_pkg.sv
hdl/lbb_cell.sv
hdl/lbb_chain.sv
hdl/lru_cache_byte_budget_unit.sv
hdl/lbb_checker.sv
dv/lru_cache_byte_budget_unit_tb.sv
